// File: rtl/ogmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogmr_pkg
// Shared constants of the occupancy grid max-pool resampler: register map,
// opcodes, cost codes and the widths of the shared multiplier and reciprocal.
// ----------------------------------------------------------------------------
package ogmr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LETHAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRINARY    = 3'd6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [7:0] COST_FREE    = 8'd0;
    localparam logic [7:0] COST_LETHAL  = 8'd254;
    localparam logic [7:0] COST_UNKNOWN = 8'd255;

    // reciprocal of the lethal threshold, ceil(2^RECIP_SHIFT / t)
    localparam int DIVISOR_W   = 7;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = RECIP_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

// File: rtl/ogmr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogmr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ogmr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogmr_mul
// Shared unsigned multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module ogmr_mul (
    input  logic                         i_clk,
    input  logic [ogmr_pkg::MUL_A_W-1:0] i_a,
    input  logic [ogmr_pkg::MUL_B_W-1:0] i_b,
    output logic [ogmr_pkg::MUL_P_W-1:0] o_p
);

    import ogmr_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: rtl/ogmr_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogmr_recip
// Bit-serial restoring divider that forms ceil(2^22 / t) for the lethal
// threshold t, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ogmr_recip (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ogmr_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                           o_busy,
    output logic [ogmr_pkg::RECIP_W-1:0]   o_recip
);

    import ogmr_pkg::*;

    localparam int CNT_W = $clog2(RECIP_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIVISOR_W-1:0] r_rem;
    logic [RECIP_W-1:0]   r_num;
    logic [RECIP_W-1:0]   r_quo;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb begin
        trial = {r_rem, r_num[RECIP_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(RECIP_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
            r_num <= (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(i_divisor) - RECIP_W'(1);
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[RECIP_W-2:0], fits};
            r_num <= {r_num[RECIP_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_busy  = r_busy;
    assign o_recip = r_quo;

endmodule

// File: rtl/occupancy_grid_maxpool_resampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_maxpool_resampler_unit
// Source occupancy grid in RAM, loaded one cell per transfer; a query returns
// the maximum cost over the source window of one output cell.
// Load: writes one cell, no result. A query first forms the window bounds on
// the shared multiplier, then reads one source cell per cycle through the
// cost pipeline (an empty window skips the scan); busy stays high until the result.
// Reset and every write of the lethal threshold start the reciprocal computation;
// busy stays high until it is done. Results cannot be stalled.
// ----------------------------------------------------------------------------
module occupancy_grid_maxpool_resampler_unit #(
    parameter int GRID_DIM   = 256,
    parameter int GRID_CELLS = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_opcode,
    input  logic [15:0]                     i_cell_index,
    input  logic [7:0]                      i_cell_value,
    input  logic [7:0]                      i_out_x,
    input  logic [7:0]                      i_out_y,
    input  logic                            i_cfg_we,
    input  logic [ogmr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ogmr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_result_valid,
    output logic [7:0]                      o_cost,
    output logic                            o_window_empty
);

    import ogmr_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);
    localparam int XW = ($clog2(GRID_CELLS + 1) > 18) ? $clog2(GRID_CELLS + 1) : 18;
    localparam logic [8:0] DIM_MAX = (GRID_DIM > 511) ? 9'd511 : 9'(GRID_DIM);
    localparam logic [XW-1:0] CELLS_END = XW'(GRID_CELLS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_CLAMP = 6'b000100,
        S_ROW   = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    // configuration
    logic [8:0]           r_src_w, r_src_h;
    logic [15:0]          r_ratio;
    logic [DIVISOR_W-1:0] r_thr;
    logic [7:0]           r_unk;
    logic                 r_trk, r_tri;
    logic                 r_recip_go;

    // sequencer
    t_state      r_state, n_state;
    logic [2:0]  r_step, n_step;
    logic        r_v1, r_v2, r_v3;
    logic        r_result_valid;

    // query datapath
    logic [7:0]    r_x, r_y;
    logic [15:0]   r_x0, r_x1, r_y0, r_y1;
    logic [8:0]    r_x0c, r_x1c, r_y1c;
    logic [8:0]    r_i, r_j;
    logic [XW-1:0] r_row;
    logic          r_oor1;
    logic [15:0]   r_n2;
    logic [7:0]    r_fix2, r_fix3;
    logic          r_scl2, r_scl3;
    logic [7:0]    r_best;
    logic [7:0]    r_cost;
    logic          r_empty;

    logic                 acc, recip_busy;
    logic [RECIP_W-1:0]   recip;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   prod;
    logic [8:0]           w, h, wm1, hm1;
    logic [15:0]          x1c, y1c;
    logic                 empty;
    logic [XW-1:0]        idx_ext, scan_addr;
    logic                 ram_we;
    logic [7:0]           rdata, v1;
    logic [7:0]           fix1, cost3;
    logic                 scl1;
    logic                 pipe_busy;
    logic                 last_col, last_row;

    assign acc    = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE) || r_recip_go || recip_busy;

    // clamped grid size
    always_comb begin
        w = (r_src_w == 9'd0) ? 9'd1 : ((r_src_w > DIM_MAX) ? DIM_MAX : r_src_w);
        h = (r_src_h == 9'd0) ? 9'd1 : ((r_src_h > DIM_MAX) ? DIM_MAX : r_src_h);
        wm1 = w - 9'd1;
        hm1 = h - 9'd1;
        x1c = (r_x1 > 16'(wm1)) ? 16'(wm1) : r_x1;
        y1c = (r_y1 > 16'(hm1)) ? 16'(hm1) : r_y1;
        empty = (r_x0 > x1c) || (r_y0 > y1c);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= 9'd256;
            r_src_h    <= 9'd256;
            r_ratio    <= 16'd256;
            r_thr      <= 7'd100;
            r_unk      <= 8'd255;
            r_trk      <= 1'b1;
            r_tri      <= 1'b1;
            r_recip_go <= 1'b1;
        end else begin
            r_recip_go <= i_cfg_we && (i_cfg_idx == CFG_LETHAL);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[8:0];
                    CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[8:0];
                    CFG_SCALE:      r_ratio <= i_cfg_data;
                    CFG_LETHAL:     r_thr   <= i_cfg_data[DIVISOR_W-1:0];
                    CFG_UNKNOWN:    r_unk   <= i_cfg_data[7:0];
                    CFG_TRACK:      r_trk   <= i_cfg_data[0];
                    CFG_TRINARY:    r_tri   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    ogmr_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_recip_go),
        .i_divisor (r_thr),
        .o_busy    (recip_busy),
        .o_recip   (recip)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = r_n2;
        mul_b = recip;
        unique case (r_state)
            S_MUL: begin
                mul_b = MUL_B_W'(r_ratio);
                unique case (r_step)
                    3'd0:    mul_a = MUL_A_W'(r_x);
                    3'd1:    mul_a = MUL_A_W'({1'b0, r_x} + 9'd1);
                    3'd2:    mul_a = MUL_A_W'(r_y);
                    3'd3:    mul_a = MUL_A_W'({1'b0, r_y} + 9'd1);
                    default: mul_a = '0;
                endcase
            end
            S_CLAMP: begin
                mul_a = MUL_A_W'(r_y0[8:0]);
                mul_b = MUL_B_W'(w);
            end
            default: ;
        endcase
    end

    ogmr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // source grid
    assign idx_ext   = XW'(i_cell_index);
    assign ram_we    = acc && (i_opcode == OP_LOAD) && (idx_ext < CELLS_END);
    assign scan_addr = r_row + XW'(r_j);

    ogmr_ram #(
        .DATA_W (8),
        .DEPTH  (GRID_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (i_cell_value),
        .i_raddr (scan_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    // cost of one source byte
    always_comb begin
        v1   = r_oor1 ? 8'd0 : rdata;
        scl1 = 1'b0;
        if (v1 == r_unk) begin
            fix1 = r_trk ? COST_UNKNOWN : COST_FREE;
        end else if (v1 >= {1'b0, r_thr}) begin
            fix1 = COST_LETHAL;
        end else begin
            fix1 = COST_FREE;
            scl1 = !r_tri;
        end
        cost3 = r_scl3 ? prod[RECIP_SHIFT +: 8] : r_fix3;
    end

    assign pipe_busy = r_v1 || r_v2 || r_v3;
    assign last_col  = (r_j == r_x1c);
    assign last_row  = (r_i == r_y1c);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = 3'd0;
                if (acc && i_opcode == OP_QUERY) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: n_state = empty ? S_IDLE : S_ROW;
            S_ROW:   n_state = S_SCAN;
            S_SCAN: begin
                if (last_col && last_row) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= 3'd0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_step         <= n_step;
            r_v1           <= (r_state == S_SCAN);
            r_v2           <= r_v1;
            r_v3           <= r_v2;
            r_result_valid <= ((r_state == S_CLAMP) && empty)
                           || ((r_state == S_DRAIN) && !pipe_busy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_x <= i_out_x;
            r_y <= i_out_y;
        end
        if (r_state == S_MUL) begin
            unique case (r_step)
                3'd1:    r_x0 <= prod[23:8];
                3'd2:    r_x1 <= prod[23:8];
                3'd3:    r_y0 <= prod[23:8];
                3'd4:    r_y1 <= prod[23:8];
                default: ;
            endcase
        end
        if (r_state == S_CLAMP) begin
            r_x0c   <= r_x0[8:0];
            r_x1c   <= x1c[8:0];
            r_y1c   <= y1c[8:0];
            r_best  <= COST_FREE;
            r_cost  <= COST_FREE;
            r_empty <= 1'b1;
        end
        if (r_state == S_ROW) begin
            r_row <= prod[XW-1:0];
            r_i   <= r_y0[8:0];
            r_j   <= r_x0c;
        end
        if (r_state == S_SCAN) begin
            r_oor1 <= (scan_addr >= CELLS_END);
            if (last_col) begin
                r_j   <= r_x0c;
                r_i   <= r_i + 9'd1;
                r_row <= r_row + XW'(w);
            end else begin
                r_j <= r_j + 9'd1;
            end
        end
        // per-cell pipeline: classify, multiply by reciprocal, take maximum
        r_n2   <= {v1, 8'd0} - {7'd0, v1, 1'b0};
        r_fix2 <= fix1;
        r_scl2 <= scl1;
        r_fix3 <= r_fix2;
        r_scl3 <= r_scl2;
        if (r_v3 && cost3 > r_best) begin
            r_best <= cost3;
        end
        if (r_state == S_DRAIN && !pipe_busy) begin
            r_cost  <= r_best;
            r_empty <= 1'b0;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_cost         = r_cost;
    assign o_window_empty = r_empty;

`ifndef ASSERT_OFF
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_DRAIN || $past(r_state) == S_CLAMP))
        else $error("result strobe without a finished query");

    a_pipe_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(r_state) == S_SCAN)
        else $error("cell read outside the scan");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> (r_j <= r_x1c && r_i <= r_y1c && r_j < w))
        else $error("scan left the window");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && !pipe_busy) |=> (r_state == S_IDLE && !r_v1))
        else $error("drain did not finish cleanly");
`endif

endmodule
